// ----- design/crcdf_pkg.sv -----
package crcdf_pkg;

  // Defaults and fixed field widths
  localparam int PAYLOAD_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH       = 4;
  localparam int LEN_W             = 6;
  localparam int IDX_W             = 5;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd22;
  localparam logic [LEN_W-1:0] LEN_SAT     = 6'd63;
  localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY    = 16'h8408;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_LEN = 2'd2
  } status_t;

  // Work passed from the framer to the back end
  typedef enum logic [1:0] {
    OP_STORE,
    OP_GOOD,
    OP_CRC_ERR,
    OP_LEN_ERR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       pkt_type;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] widx;
    logic [7:0]       dbyte;
  } cmd_t;

  // One byte of reflected CRC-16/X-25, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/crcdf_front.sv -----
module crcdf_front #(
  parameter int PAYLOAD_DEPTH = crcdf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [crcdf_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output crcdf_pkg::cmd_t             q_cmd
);
  import crcdf_pkg::*;

  localparam int CMP_W = 9;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(PAYLOAD_DEPTH);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI,
    PH_DROP
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [LEN_W-1:0] limit_r;

  logic             accept;
  logic [15:0]      crc_upd;
  logic [CMP_W-1:0] lim_eff;
  logic             len_bad;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W:0]   cnt_inc;
  logic             crc_good;

  // Take a word whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign crc_upd  = crc_feed(crc_r, in_rx_byte);
  assign lim_eff  = (CMP_W'(limit_r) > DEPTH_C) ? DEPTH_C : CMP_W'(limit_r);
  assign len_bad  = CMP_W'(in_rx_byte) > lim_eff;
  assign len_sat  = (in_rx_byte > 8'(LEN_SAT)) ? LEN_SAT : in_rx_byte[LEN_W-1:0];
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign crc_good = ({in_rx_byte, crc_lo_r} == ~crc_r);

  // Classify the word and decide what to hand to the back end
  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    q_push       = 1'b0;
    q_cmd.op       = OP_STORE;
    q_cmd.pkt_type = type_r;
    q_cmd.dlen     = len_r;
    q_cmd.widx     = cnt_r;
    q_cmd.dbyte    = in_rx_byte;
    if (accept) begin
      if (in_func) begin
        // Gap: restart framing, drop any partial packet
        phase_nxt = PH_TYPE;
        cnt_nxt   = '0;
        crc_nxt   = CRC_INIT;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            type_nxt  = in_rx_byte;
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (len_bad) begin
              q_push     = 1'b1;
              q_cmd.op   = OP_LEN_ERR;
              q_cmd.dlen = len_sat;
              phase_nxt  = PH_DROP;
            end else begin
              len_nxt   = in_rx_byte[LEN_W-1:0];
              crc_nxt   = crc_upd;
              cnt_nxt   = '0;
              phase_nxt = (in_rx_byte == 8'd0) ? PH_CRCLO : PH_DATA;
            end
          end
          PH_DATA: begin
            q_push    = (CMP_W'(cnt_r) < DEPTH_C);
            crc_nxt   = crc_upd;
            cnt_nxt   = cnt_inc[LEN_W-1:0];
            if (cnt_inc >= {1'b0, len_r}) begin
              phase_nxt = PH_CRCLO;
            end
          end
          PH_CRCLO: begin
            crc_lo_nxt = in_rx_byte;
            phase_nxt  = PH_CRCHI;
          end
          PH_CRCHI: begin
            q_push    = 1'b1;
            q_cmd.op  = crc_good ? OP_GOOD : OP_CRC_ERR;
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
            crc_nxt   = CRC_INIT;
          end
          PH_DROP: begin
            phase_nxt = PH_DROP;
          end
          default: begin
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
            crc_nxt   = CRC_INIT;
          end
        endcase
      end
    end
  end

  // Hold framing state and the length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      type_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= '0;
      limit_r  <= LIMIT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

endmodule

// ----- design/crcdf_queue.sv -----
module crcdf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crcdf_pkg::cmd_t push_cmd,
  input  logic            pop,
  output crcdf_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);
  import crcdf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   FULL_CNT  = (PW + 1)'(QUEUE_DEPTH);

  cmd_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign head  = slots_r[rp_r];
  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_SLOT) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/crcdf_back.sv -----
module crcdf_back #(
  parameter int PAYLOAD_DEPTH = crcdf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  crcdf_pkg::cmd_t             q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [1:0]                  out_reply_class,
  output logic [5:0]                  out_command_code,
  output logic [crcdf_pkg::LEN_W-1:0] out_data_length,
  output logic                        out_has_data,
  output logic [crcdf_pkg::IDX_W-1:0] out_byte_index,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last
);
  import crcdf_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int IW = (AW > LEN_W) ? AW : LEN_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } bstate_t;

  logic [7:0]       pay_mem [PAYLOAD_DEPTH];
  logic [7:0]       rd_data_r;

  bstate_t          state_r;
  logic [LEN_W-1:0] i_r;
  logic [7:0]       ptype_r;
  logic [LEN_W-1:0] plen_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [7:0]       out_type_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_has_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             out_free;
  logic             mem_we;
  logic [IW-1:0]    waddr_ext, raddr_ext;
  logic [AW-1:0]    waddr, raddr;
  logic [LEN_W:0]   i_inc;
  logic             is_last;

  logic             ld_en;
  status_t          ld_status;
  logic [7:0]       ld_type;
  logic [LEN_W-1:0] ld_len;
  logic             ld_has;
  logic [IDX_W-1:0] ld_idx;
  logic [7:0]       ld_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign waddr_ext = IW'(q_head.widx);
  assign waddr     = waddr_ext[AW-1:0];
  assign raddr_ext = IW'(i_r);
  assign raddr     = raddr_ext[AW-1:0];
  assign i_inc     = {1'b0, i_r} + 1'b1;
  assign is_last   = (i_inc == {1'b0, plen_r});

  // Pick the next command and the word to load into the output register
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    ld_en     = 1'b0;
    ld_status = ST_OK;
    ld_type   = q_head.pkt_type;
    ld_len    = q_head.dlen;
    ld_has    = 1'b0;
    ld_idx    = '0;
    ld_byte   = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.op)
            OP_STORE: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            OP_GOOD: begin
              if (q_head.dlen != '0) begin
                q_pop = 1'b1;
              end else if (out_free) begin
                // Empty good packet: one word, no data
                q_pop     = 1'b1;
                ld_en     = 1'b1;
                ld_status = ST_OK;
                ld_len    = '0;
              end
            end
            OP_CRC_ERR: begin
              if (out_free) begin
                q_pop     = 1'b1;
                ld_en     = 1'b1;
                ld_status = ST_CRC;
              end
            end
            OP_LEN_ERR: begin
              if (out_free) begin
                q_pop     = 1'b1;
                ld_en     = 1'b1;
                ld_status = ST_LEN;
              end
            end
            default: begin
              q_pop = 1'b0;
            end
          endcase
        end
      end
      B_EMIT: begin
        if (out_free) begin
          ld_en   = 1'b1;
          ld_type = ptype_r;
          ld_len  = plen_r;
          ld_has  = 1'b1;
          ld_idx  = i_r[IDX_W-1:0];
          ld_byte = rd_data_r;
        end
      end
      default: begin
        ld_en = 1'b0;
      end
    endcase
  end

  // Payload buffer: write on store, read the drain position every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[waddr] <= q_head.dbyte;
    end
    rd_data_r <= pay_mem[raddr];
  end

  // Hold drain state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ld_en) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ld_status;
        out_type_r   <= ld_type;
        out_len_r    <= ld_len;
        out_has_r    <= ld_has;
        out_idx_r    <= ld_idx;
        out_byte_r   <= ld_byte;
        out_last_r   <= ld_has ? is_last : 1'b1;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_pop && (q_head.op == OP_GOOD) && (q_head.dlen != '0)) begin
            ptype_r <= q_head.pkt_type;
            plen_r  <= q_head.dlen;
            i_r     <= '0;
            state_r <= B_READ;
          end
        end
        B_READ: begin
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            if (is_last) begin
              state_r <= B_IDLE;
            end else begin
              i_r     <= i_inc[LEN_W-1:0];
              state_r <= B_READ;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_reply_class  = out_type_r[7:6];
  assign out_command_code = out_type_r[5:0];
  assign out_data_length  = out_len_r;
  assign out_has_data     = out_has_r;
  assign out_byte_index   = out_idx_r;
  assign out_data_byte    = out_byte_r;
  assign out_last         = out_last_r;

endmodule

// ----- design/crc16_packet_deframer_core.sv -----
// Input words are taken one per cycle while the four-entry command queue has room.
// Error or empty-packet results go via the queue to the output register while the back end idles.
// A good packet's payload is read word by word from the buffer (B_READ) and loaded into the
// output register (B_EMIT), held while the output stalls; a full queue stalls input.
// Reset (synchronous, rst_n low) restarts framing, empties the queue and output, and sets
// length_limit to 22; the payload buffer is not cleared and needs no clearing pass.
module crc16_packet_deframer_core #(
  parameter int PAYLOAD_DEPTH = crcdf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [crcdf_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [1:0]                  out_reply_class,
  output logic [5:0]                  out_command_code,
  output logic [crcdf_pkg::LEN_W-1:0] out_data_length,
  output logic                        out_has_data,
  output logic [crcdf_pkg::IDX_W-1:0] out_byte_index,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last
);
  import crcdf_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_cmd, q_head;

  // Framer: classify each received word
  crcdf_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  // Decouple the framer from the drain
  crcdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Buffer payload and emit results
  crcdf_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_reply_class  (out_reply_class),
    .out_command_code (out_command_code),
    .out_data_length  (out_data_length),
    .out_has_data     (out_has_data),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_last && !out_has_data))
    else $error("error result not a single last word");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import crcdf_pkg::*;

  localparam int DEPTH        = PAYLOAD_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_CYCLES = 24;
  localparam int PHASE_WORDS  = 65;
  localparam int DIR_ROWS     = 29;

  // Framing position of the predictor
  typedef enum logic [2:0] {
    FR_TYPE,
    FR_LEN,
    FR_BODY,
    FR_CRC_LO,
    FR_CRC_HI,
    FR_DISCARD
  } frame_phase_t;

  // What a directed row puts on the input
  typedef enum logic [1:0] {
    K_GAP,
    K_BYTE,
    K_CRC_LO,
    K_CRC_HI
  } word_kind_t;

  typedef struct packed {
    status_t          status;
    logic [1:0]       rclass;
    logic [5:0]       code;
    logic [LEN_W-1:0] dlen;
    logic             has;
    logic [IDX_W-1:0] idx;
    logic [7:0]       dbyte;
    logic             last;
  } frame_res_t;

  // CRC rows use val as a corruption mask on the good CRC byte
  typedef struct packed {
    word_kind_t       kind;
    logic [7:0]       val;
    logic             typed;
    status_t          st;
    logic [1:0]       rc;
    logic [5:0]       cc;
    logic [LEN_W-1:0] dl;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [LEN_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = 1'b0;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [1:0]           out_reply_class;
  logic [5:0]           out_command_code;
  logic [LEN_W-1:0]     out_data_length;
  logic                 out_has_data;
  logic [IDX_W-1:0]     out_byte_index;
  logic [7:0]           out_data_byte;
  logic                 out_last;

  // Predictor state
  frame_phase_t         fr_phase = FR_TYPE;
  logic [7:0]           type_q = 8'h00;
  logic [LEN_W-1:0]     len_q = '0;
  logic [LEN_W-1:0]     body_cnt = '0;
  logic [15:0]          crc_acc = 16'hFFFF;
  logic [7:0]           crc_lo_q = 8'h00;
  logic [7:0]           body_mem [DEPTH];
  logic [LEN_W-1:0]     cur_limit = LIMIT_RESET;

  frame_res_t           pending_q [$];
  frame_res_t           no_res = '0;
  dir_row_t             dir_tab [DIR_ROWS];

  bit                   idle_on = 1'b1;
  int                   stall_left = 0;
  int                   cycles = 0;
  int                   mismatches = 0;
  int                   words_in = 0;
  int                   results_checked = 0;
  int                   good_pkts = 0;
  int                   crc_errs = 0;
  int                   len_errs = 0;
  int                   limits_set = 0;

  crc16_packet_deframer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_reply_class  (out_reply_class),
    .out_command_code (out_command_code),
    .out_data_length  (out_data_length),
    .out_has_data     (out_has_data),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  // Reflected CRC-16/X-25, one byte, lsb first
  function automatic logic [15:0] x25_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    int          k;
    c = acc;
    for (k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 40) begin
      $display("MISMATCH cycle %0d: %s", cycles, what);
    end
    mismatches++;
  endtask

  task automatic put_result(input status_t st, input logic [LEN_W-1:0] dl, input logic has,
                            input logic [IDX_W-1:0] ix, input logic [7:0] db,
                            input logic lst, input bit keep);
    frame_res_t r;
    r.status = st;
    r.rclass = type_q[7:6];
    r.code   = type_q[5:0];
    r.dlen   = dl;
    r.has    = has;
    r.idx    = ix;
    r.dbyte  = db;
    r.last   = lst;
    if (keep) begin
      pending_q.push_back(r);
    end
  endtask

  // Advance the deframer prediction by one accepted word
  task automatic deframe_word(input logic f, input logic [7:0] b, input bit keep);
    logic [LEN_W-1:0] lim;
    int               i;
    if (f) begin
      fr_phase = FR_TYPE;
      body_cnt = '0;
      crc_acc  = CRC_INIT;
      return;
    end
    if (fr_phase != FR_DISCARD) begin
      words_in++;
    end
    case (fr_phase)
      FR_TYPE: begin
        type_q   = b;
        crc_acc  = x25_step(crc_acc, b);
        fr_phase = FR_LEN;
      end
      FR_LEN: begin
        lim = (cur_limit > DEPTH) ? LEN_W'(DEPTH) : cur_limit;
        if (b > lim) begin
          put_result(ST_LEN, (b > 8'd63) ? LEN_SAT : b[LEN_W-1:0], 1'b0, '0, 8'h00, 1'b1,
                     keep);
          len_errs++;
          fr_phase = FR_DISCARD;
        end else begin
          len_q    = b[LEN_W-1:0];
          crc_acc  = x25_step(crc_acc, b);
          body_cnt = '0;
          fr_phase = (b == 8'h00) ? FR_CRC_LO : FR_BODY;
        end
      end
      FR_BODY: begin
        if (body_cnt < DEPTH) begin
          body_mem[body_cnt] = b;
        end
        crc_acc  = x25_step(crc_acc, b);
        body_cnt = body_cnt + 1'b1;
        if (body_cnt >= len_q) begin
          fr_phase = FR_CRC_LO;
        end
      end
      FR_CRC_LO: begin
        crc_lo_q = b;
        fr_phase = FR_CRC_HI;
      end
      FR_CRC_HI: begin
        if ({b, crc_lo_q} == ~crc_acc) begin
          good_pkts++;
          if (len_q == 0) begin
            put_result(ST_OK, '0, 1'b0, '0, 8'h00, 1'b1, keep);
          end else begin
            for (i = 0; i < len_q && i < DEPTH; i++) begin
              put_result(ST_OK, len_q, 1'b1, IDX_W'(i), body_mem[i], (i + 1 == len_q), keep);
            end
          end
        end else begin
          crc_errs++;
          put_result(ST_CRC, len_q, 1'b0, '0, 8'h00, 1'b1, keep);
        end
        fr_phase = FR_TYPE;
        body_cnt = '0;
        crc_acc  = CRC_INIT;
      end
      default: begin
        // discard until a gap
      end
    endcase
  endtask

  // Drive one word, hold it until taken, then predict
  task automatic send_word(input logic f, input logic [7:0] b, input bit typed_on,
                           input frame_res_t typed);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_word(f, b, !typed_on);
    if (typed_on) begin
      pending_q.push_back(typed);
    end
  endtask

  task automatic bus_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write the length limit once the block has gone quiet
  task automatic set_limit(input logic [LEN_W-1:0] v);
    bus_idle();
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
    limits_set++;
  endtask

  // One random framing episode: mostly clean packets, some errors and noise
  task automatic send_episode();
    logic [7:0]  bytes_q [$];
    logic [15:0] crc;
    logic [7:0]  len;
    int          eff, hi, r, i, n;
    eff = (cur_limit > DEPTH) ? DEPTH : int'(cur_limit);
    r = $urandom_range(0, 99);
    if (fr_phase != FR_TYPE || r < 10) begin
      send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, no_res);
    end
    if (r < 75) begin
      hi  = (eff < 6) ? eff : 6;
      len = ($urandom_range(0, 7) == 0) ? 8'(eff) : 8'($urandom_range(0, hi));
      bytes_q.push_back(8'($urandom_range(0, 255)));
      bytes_q.push_back(len);
      for (i = 0; i < len; i++) begin
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end
      crc = CRC_INIT;
      foreach (bytes_q[j]) begin
        crc = x25_step(crc, bytes_q[j]);
      end
      crc = ~crc;
      if ($urandom_range(0, 5) == 0) begin
        crc = crc ^ (16'd1 << $urandom_range(0, 15));
      end
      bytes_q.push_back(crc[7:0]);
      bytes_q.push_back(crc[15:8]);
      // cut some packets short, then restart with a gap
      n = bytes_q.size();
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, bytes_q.size() - 1);
      end
      for (i = 0; i < n; i++) begin
        send_word(1'b0, bytes_q[i], 1'b0, no_res);
      end
      if (n != bytes_q.size()) begin
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, no_res);
      end
    end else if (r < 88) begin
      send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, no_res);
      len = $urandom_range(0, 1) ? 8'(eff + 1) : 8'($urandom_range(eff + 1, 255));
      send_word(1'b0, len, 1'b0, no_res);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
        send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, no_res);
      end
    end else begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        send_word(($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)), 1'b0, no_res);
      end
    end
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    frame_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_mismatch("result word with nothing expected");
      end else begin
        want = pending_q.pop_front();
        results_checked++;
        if (out_status !== want.status || out_reply_class !== want.rclass ||
            out_command_code !== want.code || out_data_length !== want.dlen ||
            out_has_data !== want.has || out_byte_index !== want.idx ||
            out_data_byte !== want.dbyte || out_last !== want.last) begin
          note_mismatch({
            $sformatf("got st%0d rc%0d cc%0d dl%0d hd%0d ix%0d db%02h l%0d",
                      out_status, out_reply_class, out_command_code, out_data_length,
                      out_has_data, out_byte_index, out_data_byte, out_last),
            $sformatf(" / want st%0d rc%0d cc%0d dl%0d hd%0d ix%0d db%02h l%0d",
                      want.status, want.rclass, want.code, want.dlen, want.has,
                      want.idx, want.dbyte, want.last)});
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    frame_res_t typed;
    logic [15:0] good;
    logic [7:0]  b;
    logic        f;
    int          r, p, goal;

    dir_tab = '{
      // gap at the start, then an empty packet with an all-ones type
      '{K_GAP,    8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'hFF, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_LO, 8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_HI, 8'h00, 1'b1, ST_OK,  2'd3, 6'd63, 6'd0},
      // length 255 saturates, following bytes are dropped
      '{K_BYTE,   8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'hFF, 1'b1, ST_LEN, 2'd0, 6'd0,  6'd63},
      '{K_BYTE,   8'h55, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_GAP,    8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      // one over the reset limit
      '{K_BYTE,   8'h81, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h17, 1'b1, ST_LEN, 2'd2, 6'd1,  6'd23},
      '{K_GAP,    8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      // two-byte good packet with extreme payload bytes
      '{K_BYTE,   8'h42, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h02, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'hFF, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_LO, 8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_HI, 8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      // back to back packet with a bad low CRC byte
      '{K_BYTE,   8'hC5, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h01, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h3C, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_LO, 8'h01, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_HI, 8'h00, 1'b1, ST_CRC, 2'd3, 6'd5,  6'd1},
      // type straight after a CRC error, then a gap drops it
      '{K_BYTE,   8'h3F, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_GAP,    8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      // empty packet with a bad high CRC byte
      '{K_BYTE,   8'h07, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_BYTE,   8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_LO, 8'h00, 1'b0, ST_OK,  2'd0, 6'd0,  6'd0},
      '{K_CRC_HI, 8'h80, 1'b1, ST_CRC, 2'd0, 6'd7,  6'd0}
    };

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset limit
    for (r = 0; r < DIR_ROWS; r++) begin
      row  = dir_tab[r];
      good = ~crc_acc;
      f    = (row.kind == K_GAP);
      case (row.kind)
        K_GAP:    b = 8'($urandom_range(0, 255));
        K_CRC_LO: b = good[7:0] ^ row.val;
        K_CRC_HI: b = good[15:8] ^ row.val;
        default:  b = row.val;
      endcase
      typed        = '0;
      typed.status = row.st;
      typed.rclass = row.rc;
      typed.code   = row.cc;
      typed.dlen   = row.dl;
      typed.last   = 1'b1;
      send_word(f, b, row.typed, typed);
    end

    // Random episodes under several limits; the last phase runs without idling
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       set_limit(6'd32);
        1:       set_limit(6'd0);
        2:       set_limit(6'd63);
        3:       set_limit(6'd1);
        4:       set_limit(6'($urandom_range(2, 31)));
        default: set_limit(LIMIT_RESET);
      endcase
      idle_on = (p != 5);
      goal = words_in + PHASE_WORDS;
      while (words_in < goal) begin
        send_episode();
      end
    end

    // Drain and report
    bus_idle();
    wait_drained();
    $display("Covered %0d framed input words over %0d limit settings plus reset default.",
             words_in, limits_set);
    $display("Checked %0d result words: %0d good packets, %0d CRC errors, %0d length errors.",
             results_checked, good_pkts, crc_errs, len_errs);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
